// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every rising clock edge outside reset.
`define SPQ_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition at one edge implies a consequence at the next edge.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

   localparam int PRIO_W = 5;
   localparam int TAG_W  = 32;
   localparam int OCC_W  = 5;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_SHIFT  = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic              valid;
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      cell_op_type       op;
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } cell_ctrl_type;

endpackage

// ===== sv/spq_if.sv =====
interface spq_req_if;
   import spq_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [PRIO_W-1:0] priority_req;
   logic [TAG_W-1:0]  request_tag;

   modport source (output valid, output command, output priority_req, output request_tag,
                   input ready);
   modport sink (input valid, input command, input priority_req, input request_tag,
                 output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [PRIO_W-1:0] out_priority;
   logic [TAG_W-1:0]  out_tag;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, output status, output out_priority, output out_tag,
                   output occupancy, input ready);
   modport sink (input valid, input status, input out_priority, input out_tag,
                 input occupancy, output ready);
endinterface

// ===== sv/spq_cell.sv =====
module spq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type     prev_entry,
   input  logic                   prev_keep,
   input  spq_pkg::entry_type     next_entry,
   output spq_pkg::entry_type     entry,
   output logic                   keep
);
   import spq_pkg::*;

   logic              valid_ff, valid_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;

   // Stay in place on insert: held and at least as urgent as the newcomer.
   assign keep = valid_ff && (prio_ff >= ctrl.prio);

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      tag_in   = tag_ff;
      unique case (ctrl.op)
         OP_INSERT: begin
            if (!keep) begin
               if (prev_keep) begin
                  valid_in = 1'b1;
                  prio_in  = ctrl.prio;
                  tag_in   = ctrl.tag;
               end else begin
                  valid_in = prev_entry.valid;
                  prio_in  = prev_entry.prio;
                  tag_in   = prev_entry.tag;
               end
            end
         end
         OP_SHIFT: begin
            valid_in = next_entry.valid;
            prio_in  = next_entry.prio;
            tag_in   = next_entry.tag;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign entry = '{valid: valid_ff, prio: prio_ff, tag: tag_ff};

endmodule

// ===== sv/stable_priority_queue.sv =====
// Stable priority queue of CAPACITY entries built as a row of cells, head in
// cell 0. Each beat on req_if either enqueues (priority, tag) or dequeues the
// head; each accepted beat yields exactly one beat on rsp_if with a status,
// the dequeued priority and tag (zero unless a dequeue succeeded) and the
// occupancy after the operation, modulo 32. Larger priorities leave first and
// equal priorities leave in arrival order. An enqueue to a full queue is
// rejected with status full, a dequeue on an empty queue reports empty. Every
// cell decides its next contents from its own entry and its neighbors, so one
// beat is taken per clock while responses are taken as they come;
// a new beat is accepted at the same edge at which the waiting result is taken,
// and req_if stalls only while that result is held by a downstream stall.
// The response is registered and appears in the cycle after the beat is accepted.
module stable_priority_queue #(
   parameter int CAPACITY = 16
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);
   import spq_pkg::*;
   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [PRIO_W-1:0] out_prio_ff, out_prio_in;
   logic [TAG_W-1:0]  out_tag_ff, out_tag_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;

   logic          accept;
   logic          full;
   cell_ctrl_type ctrl;
   entry_type     cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_keep;

   // Take a beat whenever the output register is free or drains this cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      ctrl.op      = OP_HOLD;
      ctrl.prio    = req_if.priority_req;
      ctrl.tag     = req_if.request_tag;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      out_prio_in  = out_prio_ff;
      out_tag_in   = out_tag_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_prio_in  = '0;
         out_tag_in   = '0;
         if (req_if.command == CMD_ENQUEUE) begin
            if (full) begin
               // drop the entry, leave the row as it is
               status_in = ST_FULL;
            end else begin
               ctrl.op   = OP_INSERT;
               status_in = ST_ENQUEUED;
               count_in  = count_ff + 1'b1;
            end
         end else begin
            if (cell_entry[0].valid) begin
               // advance the row one cell toward the head
               ctrl.op     = OP_SHIFT;
               status_in   = ST_DEQUEUED;
               out_prio_in = cell_entry[0].prio;
               out_tag_in  = cell_entry[0].tag;
               count_in    = count_ff - 1'b1;
            end else begin
               status_in = ST_EMPTY;
            end
         end
      end
      occ_in = (accept) ? OCC_W'(count_in) : occ_ff;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         entry_type prev_e;
         entry_type next_e;
         logic      prev_k;
         if (gi == 0) begin : g_head
            assign prev_e = '0;
            assign prev_k = 1'b1;
         end else begin : g_body
            assign prev_e = cell_entry[gi-1];
            assign prev_k = cell_keep[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign next_e = '0;
         end else begin : g_inner
            assign next_e = cell_entry[gi+1];
         end
         spq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_entry (prev_e),
            .prev_keep  (prev_k),
            .next_entry (next_e),
            .entry      (cell_entry[gi]),
            .keep       (cell_keep[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload until the beat is taken.
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      out_prio_ff <= out_prio_in;
      out_tag_ff  <= out_tag_in;
      occ_ff      <= occ_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.out_priority = out_prio_ff;
   assign rsp_if.out_tag      = out_tag_ff;
   assign rsp_if.occupancy    = occ_ff;

   `SPQ_ASSERT_HOLDS(a_head_matches_count, clock, reset,
      cell_entry[0].valid == (count_ff != '0), "head valid disagrees with entry count")
   `SPQ_ASSERT_HOLDS(a_tail_matches_full, clock, reset,
      cell_entry[CAPACITY-1].valid == full, "tail valid disagrees with full flag")
   `SPQ_ASSERT_NEXT(a_enqueue_counts, clock, reset,
      !reset && accept && req_if.command == CMD_ENQUEUE && !full,
      count_ff == CNT_W'($past(count_ff) + 1'b1), "enqueue did not grow the count")

endmodule

// ===== tb/stable_priority_queue_tb.sv =====
module stable_priority_queue_tb;
   import spq_pkg::*;

   localparam int CAPACITY   = 16;
   localparam int IDLE_LIMIT = 2000;   // cycles without any beat before giving up
   localparam int DRAIN_WAIT = 4;      // slack after the last owed response
   localparam int RAND_ITEMS = 900;

   // One response beat as the queue should report it.
   typedef struct packed {
      status_type        status;
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
      logic [OCC_W-1:0]  occ;
   } queue_rsp_type;

   // One row of the directed table. When typed is set, want holds the response
   // written out by hand; otherwise the shadow queue decides it.
   typedef struct packed {
      logic              cmd;
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
      logic              typed;
      queue_rsp_type     want;
   } stim_row_type;

   localparam queue_rsp_type UNTYPED = '{ST_ENQUEUED, 5'd0, 32'd0, 5'd0};
   localparam int N_ROWS = 23;

   // Directed table: empty dequeue after reset, extremes of priority and tag,
   // ties in both the top and the middle priority, a fill to capacity, an
   // enqueue rejected as full and a dequeue from the full queue.
   stim_row_type directed_rows [N_ROWS] = '{
      '{CMD_DEQUEUE, 5'd0,  32'h0000_0000, 1'b1, '{ST_EMPTY,    5'd0,  32'd0,         5'd0}},
      '{CMD_ENQUEUE, 5'd31, 32'hFFFF_FFFF, 1'b1, '{ST_ENQUEUED, 5'd0,  32'd0,         5'd1}},
      '{CMD_ENQUEUE, 5'd0,  32'h0000_0000, 1'b1, '{ST_ENQUEUED, 5'd0,  32'd0,         5'd2}},
      '{CMD_ENQUEUE, 5'd31, 32'h0000_0001, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd16, 32'hAAAA_AAAA, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd16, 32'h5555_5555, 1'b0, UNTYPED},
      '{CMD_DEQUEUE, 5'd31, 32'hFFFF_FFFF, 1'b1, '{ST_DEQUEUED, 5'd31, 32'hFFFF_FFFF, 5'd4}},
      '{CMD_DEQUEUE, 5'd0,  32'h0000_0000, 1'b1, '{ST_DEQUEUED, 5'd31, 32'h0000_0001, 5'd3}},
      '{CMD_ENQUEUE, 5'd1,  32'h1111_0001, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd2,  32'h2222_0002, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd4,  32'h4444_0004, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd8,  32'h8888_0008, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd16, 32'h0F0F_0F0F, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd31, 32'hF0F0_F0F0, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd0,  32'h8000_0000, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd16, 32'h1234_5678, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd7,  32'h7777_7777, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd23, 32'h2323_2323, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd31, 32'hCAFE_0031, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd1,  32'h0000_0101, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd30, 32'h3030_3030, 1'b0, UNTYPED},
      '{CMD_ENQUEUE, 5'd5,  32'hDEAD_BEEF, 1'b1, '{ST_FULL,     5'd0,  32'd0,         5'd16}},
      '{CMD_DEQUEUE, 5'd0,  32'h0000_0000, 1'b0, UNTYPED}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   stable_priority_queue #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the queue: head at index 0, held entries form a prefix.
   logic [PRIO_W-1:0] held_prio [CAPACITY];
   logic [TAG_W-1:0]  held_tag  [CAPACITY];
   int                held = 0;

   queue_rsp_type pending_rsp [$];   // responses still owed by the block, oldest first
   int            mismatches = 0;
   bit            quiet = 1'b0;      // suppress idling on both sides for a stretch
   int            idle_cycles = 0;

   // Apply one request to the shadow queue and return the response it causes.
   function automatic queue_rsp_type apply_request(logic cmd, logic [PRIO_W-1:0] prio,
                                                   logic [TAG_W-1:0] tag);
      queue_rsp_type r;
      int            pos;
      r = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (held >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            // Insert behind every entry of equal or higher priority.
            pos = 0;
            while (pos < held && held_prio[pos] >= prio) pos++;
            for (int i = held; i > pos; i--) begin
               held_prio[i] = held_prio[i-1];
               held_tag[i]  = held_tag[i-1];
            end
            held_prio[pos] = prio;
            held_tag[pos]  = tag;
            held++;
            r.status = ST_ENQUEUED;
         end
      end else if (held == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.status = ST_DEQUEUED;
         r.prio   = held_prio[0];
         r.tag    = held_tag[0];
         for (int i = 0; i + 1 < held; i++) begin
            held_prio[i] = held_prio[i+1];
            held_tag[i]  = held_tag[i+1];
         end
         held--;
      end
      r.occ = OCC_W'(held);
      return r;
   endfunction

   // Gap length: mostly short, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive one request beat, hold it until accepted, then record what the
   // response must be. Inputs change on the falling edge only.
   task automatic send_beat(logic cmd, logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag,
                            bit typed, queue_rsp_type want);
      int            gap;
      queue_rsp_type predicted;
      gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : gap_len();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        = 1'b1;
      req_if.command      = cmd;
      req_if.priority_req = prio;
      req_if.request_tag  = tag;
      do @(posedge clock); while (!req_if.ready);
      // Accepted at this edge: advance the shadow queue even for typed rows.
      predicted = apply_request(cmd, prio, tag);
      pending_rsp.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Stimulus: reset, the directed table, then random phases that swing the
   // queue between full and empty with random content.
   initial begin : stimulus
      int            sent;
      int            block_len;
      int            enq_pct;
      logic          cmd;
      logic [PRIO_W-1:0] prio;
      req_if.valid        = 1'b0;
      req_if.command      = CMD_ENQUEUE;
      req_if.priority_req = '0;
      req_if.request_tag  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].cmd, directed_rows[i].prio, directed_rows[i].tag,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      sent = 0;
      while (sent < RAND_ITEMS) begin
         // Pick a phase: fill-heavy, drain-heavy or balanced.
         block_len = $urandom_range(20, 60);
         case ($urandom_range(0, 3))
            0: enq_pct = 95;
            1: enq_pct = 80;
            2: enq_pct = 50;
            default: enq_pct = 20;
         endcase
         quiet = ($urandom_range(0, 3) == 0);
         repeat (block_len) begin
            cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
            // Crowd a narrow band now and then to force ties.
            prio = ($urandom_range(0, 2) == 0) ? PRIO_W'($urandom_range(0, 3))
                                               : PRIO_W'($urandom_range(0, 31));
            send_beat(cmd, prio, $urandom, 1'b0, UNTYPED);
            sent++;
         end
      end
      req_if.valid = 1'b0;
      quiet = 1'b0;

      // Drain: wait for every owed response, then the DRAIN_WAIT slack for strays.
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Response side: hold ready low for random stretches unless quiet.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_if.ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (quiet || $urandom_range(0, 99) < 70) begin
            rsp_if.ready = 1'b1;
         end else begin
            rsp_if.ready = 1'b0;
            stall_left = gap_len() - 1;
         end
      end
   end

   // Compare every accepted response beat with the oldest owed response.
   always @(posedge clock) begin : check_rsp
      queue_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_if.status);
               mismatches++;
            end
            if (rsp_if.out_priority !== want.prio) begin
               $error("out_priority: expected %0d, got %0d", want.prio, rsp_if.out_priority);
               mismatches++;
            end
            if (rsp_if.out_tag !== want.tag) begin
               $error("out_tag: expected %h, got %h", want.tag, rsp_if.out_tag);
               mismatches++;
            end
            if (rsp_if.occupancy !== want.occ) begin
               $error("occupancy: expected %0d, got %0d", want.occ, rsp_if.occupancy);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: count cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
tb/stable_priority_queue_tb.sv
